/* rtl/core/f2s_pkg.sv */
// f2s_pkg: shared types and constants for the float to s16 converter.
// No dependencies; used by f2s_int_round and the top level.
`default_nettype none
package f2s_pkg;

    localparam int unsigned MANT_W  = 24;
    localparam int unsigned SCALE_W = 15;
    localparam int unsigned PROD_W  = MANT_W + SCALE_W;
    localparam int unsigned INT_W   = 17;

    localparam logic [SCALE_W-1:0] PCM_SCALE = 15'd32767;

    // exponent window in which the scaled value can round to a nonzero integer
    localparam logic [7:0] EXP_LOW  = 8'd109;
    localparam logic [7:0] EXP_EDGE = 8'd128;
    localparam logic [7:0] EXP_SPEC = 8'd255;
    localparam logic [7:0] SHIFT_BASE = 8'd150;

    localparam logic [15:0] PCM_POS_MAX = 16'h7fff;
    localparam logic [15:0] PCM_NEG_MIN = 16'h8000;

    typedef enum logic [1:0] {
        MODE_AWAY        = 2'd0,
        MODE_TOWARD_ZERO = 2'd1,
        MODE_EVEN        = 2'd2
    } round_mode_t;

    typedef struct packed {
        logic sign;
        logic nan;
        logic ovf;
        logic zero;
    } f2s_flags_t;

endpackage
`default_nettype wire

/* rtl/core/f2s_int_round.sv */
// f2s_int_round: integer rounding under the selected mode plus saturation.
// Depends on f2s_pkg.
`default_nettype none
module f2s_int_round (
    input  wire logic [1:0]               mode,
    input  wire f2s_pkg::f2s_flags_t      flags,
    input  wire logic [f2s_pkg::INT_W-1:0] int_mag,
    input  wire logic                     half,
    input  wire logic                     sticky,
    output logic      [15:0]              pcm_value,
    output logic                          clipped
);
    import f2s_pkg::*;

    logic                inc;
    logic [INT_W:0]      mag;

    always_comb begin
        unique case (mode)
            MODE_AWAY:        inc = half;
            MODE_TOWARD_ZERO: inc = 1'b0;
            default:          inc = half & (sticky | int_mag[0]);
        endcase
        mag = {1'b0, int_mag} + {{INT_W{1'b0}}, inc};

        priority if (flags.nan) begin
            pcm_value = '0;
            clipped   = 1'b1;
        end else if (flags.zero) begin
            pcm_value = '0;
            clipped   = 1'b0;
        end else if (flags.ovf) begin
            pcm_value = flags.sign ? PCM_NEG_MIN : PCM_POS_MAX;
            clipped   = 1'b1;
        end else if (!flags.sign) begin
            clipped   = (mag > {2'b00, PCM_POS_MAX});
            pcm_value = clipped ? PCM_POS_MAX : mag[15:0];
        end else begin
            clipped   = (mag > {2'b00, PCM_NEG_MIN});
            pcm_value = clipped ? PCM_NEG_MIN : 16'(~mag[15:0] + 16'd1);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/float_to_s16_rounding_converter_core.sv */
// float_to_s16_rounding_converter_core: float32 sample to s16 PCM, four-stage pipeline.
// Depends on f2s_pkg and f2s_int_round.
//
// Usage:
//   Input channel s_valid/s_ready carries s_sample_bits, one IEEE-754 single
//   per transfer. Output channel m_valid/m_ready carries m_pcm_value (signed
//   16-bit) and m_clipped. cfg_we/cfg_wdata write the rounding mode
//   (0 half away from zero, 1 toward zero, 2 or 3 nearest even).
//   The transfer itself loads the multiply stage; the next stages round the
//   product to 24 significant bits, align by the exponent, and integer round
//   and saturate into the output register, whose valid bit drives m_valid.
//   Throughput is one transfer per cycle; every stage has its own valid bit
//   and advances whenever the stage after it is empty or moving, so bubbles
//   collapse and a stalled receiver only backs up as far as it must.
//   When m_ready is low, the output register holds; earlier stages fill and
//   s_ready drops once all four are occupied. Nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline and sets mode 0.
//   Change the mode only with the pipeline drained.
`default_nettype none
module float_to_s16_rounding_converter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_sample_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_pcm_value,
    output logic             m_clipped
);
    import f2s_pkg::*;

    logic [1:0] mode_reg;

    // stage 1: product of mantissa and scale
    logic              v1_reg;
    logic              sign1_reg, nan1_reg;
    logic [7:0]        exp1_reg;
    logic [PROD_W-1:0] prod1_reg;

    // stage 2: product rounded to float precision
    logic              v2_reg;
    f2s_flags_t        flags2_reg;
    logic [5:0]        shamt2_reg;
    logic [PROD_W:0]   rnd2_reg;

    // stage 3: aligned integer with guard and sticky
    logic              v3_reg;
    f2s_flags_t        flags3_reg;
    logic [INT_W-1:0]  int3_reg;
    logic              half3_reg, sticky3_reg;

    logic              out_valid_reg, out_clip_reg;
    logic [15:0]       out_pcm_reg;

    logic rdy1, rdy2, rdy3;

    // advance a stage when its successor is empty or moving
    assign rdy3    = !out_valid_reg | m_ready;
    assign rdy2    = !v3_reg | rdy3;
    assign rdy1    = !v2_reg | rdy2;
    assign s_ready = !v1_reg | rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_AWAY;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // stage 1 datapath
    logic [7:0]        s_exp;
    logic [MANT_W-1:0] s_mant;
    assign s_exp  = s_sample_bits[30:23];
    assign s_mant = {(s_exp != 8'd0), s_sample_bits[22:0]};

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            sign1_reg <= s_sample_bits[31];
            exp1_reg  <= s_exp;
            nan1_reg  <= (s_exp == EXP_SPEC) && (s_sample_bits[22:0] != 23'd0);
            prod1_reg <= PROD_W'(s_mant) * PROD_W'(PCM_SCALE);
        end
    end

    // stage 2 datapath: round to 24 significant bits, nearest even
    logic            hi;
    logic            lsb1, grd1, stk1, up1;
    logic [PROD_W:0] rnd_next;
    f2s_flags_t      flags_next;

    always_comb begin
        hi = prod1_reg[PROD_W-1];
        if (hi) begin
            lsb1 = prod1_reg[15];
            grd1 = prod1_reg[14];
            stk1 = |prod1_reg[13:0];
        end else begin
            lsb1 = prod1_reg[14];
            grd1 = prod1_reg[13];
            stk1 = |prod1_reg[12:0];
        end
        up1 = grd1 & (stk1 | lsb1);
        if (hi) begin
            rnd_next = {(25'({1'b0, prod1_reg[38:15]}) + 25'(up1)), 15'd0};
        end else begin
            rnd_next = {1'b0, (25'({1'b0, prod1_reg[37:14]}) + 25'(up1)), 14'd0};
        end
        flags_next.sign = sign1_reg;
        flags_next.nan  = nan1_reg;
        flags_next.ovf  = (exp1_reg > EXP_EDGE) || ((exp1_reg == EXP_EDGE) && hi);
        flags_next.zero = (exp1_reg < EXP_LOW);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            flags2_reg <= flags_next;
            shamt2_reg <= 6'(SHIFT_BASE - exp1_reg);
            rnd2_reg   <= rnd_next;
        end
    end

    // stage 3 datapath: shift right by the exponent, keep half and sticky
    logic [2*PROD_W+3:0] ext;
    assign ext = {rnd2_reg, 42'd0} >> shamt2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            flags3_reg  <= flags2_reg;
            int3_reg    <= ext[58:42];
            half3_reg   <= ext[41];
            sticky3_reg <= |ext[40:0];
        end
    end

    // stage 4: integer rounding and saturation into the output register
    logic [15:0] pcm_next;
    logic        clip_next;

    f2s_int_round u_round (
        .mode      (mode_reg),
        .flags     (flags3_reg),
        .int_mag   (int3_reg),
        .half      (half3_reg),
        .sticky    (sticky3_reg),
        .pcm_value (pcm_next),
        .clipped   (clip_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            out_pcm_reg  <= pcm_next;
            out_clip_reg <= clip_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) v1_reg        <= s_valid;
            if (rdy1)    v2_reg        <= v1_reg;
            if (rdy2)    v3_reg        <= v2_reg;
            if (rdy3)    out_valid_reg <= v3_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pcm_value = out_pcm_reg;
    assign m_clipped   = out_clip_reg;

endmodule
`default_nettype wire

/* tb/float_to_s16_rounding_converter_core_tb.sv */
// Self-checking testbench for float_to_s16_rounding_converter_core.
// Depends on f2s_pkg (round_mode_t, PCM_SCALE) and the core; predicts in integer math.
`default_nettype none
module float_to_s16_rounding_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import f2s_pkg::*;

    // mode code 3 is unused by the enum and behaves as nearest even
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 540;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic signed [15:0] pcm;
        logic               clip;
    } pcm_result_t;

    typedef struct {
        logic [31:0]        bits;
        bit                 fixed;
        logic signed [15:0] pcm;
        logic               clip;
    } sample_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_sample_bits = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_pcm_value;
    logic        m_clipped;

    logic [1:0]  active_mode = MODE_AWAY;
    pcm_result_t pending_pcm_q[$];
    int          error_count = 0;
    int          pcm_transfers = 0;
    int          cycle_count = 0;

    float_to_s16_rounding_converter_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_bits (s_sample_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pcm_value   (m_pcm_value),
        .m_clipped     (m_clipped)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("float_to_s16_rounding_converter_core_tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // Scale by 32767 exactly, round to a 24-bit significand (nearest even),
    // then round to integer under the mode and saturate.
    function automatic logic [127:0] to_fixed(input logic [39:0] val, input int sh);
        logic [127:0] wide;
        wide = {88'd0, val};
        if (sh >= 0) return wide << sh;
        return wide >> (-sh);
    endfunction

    function automatic pcm_result_t predict_pcm(input logic [31:0] bits,
                                                input logic [1:0] mode);
        pcm_result_t  r;
        logic         sgn;
        logic [7:0]   ex;
        logic [23:0]  sig;
        logic [39:0]  prod, kept, rem, halfway;
        logic [127:0] fx;
        logic [63:0]  ip, fr, mag;
        int           sh, msb, drop;
        sgn = bits[31];
        ex = bits[30:23];
        sig = {ex != 8'd0, bits[22:0]};
        r.pcm = 16'sd0;
        r.clip = 1'b0;
        if (ex == 8'hff && bits[22:0] != 23'd0) begin
            r.clip = 1'b1;
            return r;
        end
        // infinity and anything of magnitude 2^13 or more is far out of range
        if (ex >= 8'd140) begin
            r.pcm = sgn ? 16'sh8000 : 16'sh7fff;
            r.clip = 1'b1;
            return r;
        end
        prod = 40'(sig) * 40'(PCM_SCALE);
        sh = ((ex == 8'd0) ? 1 : int'(ex)) - 86;
        fx = to_fixed(prod, sh);
        if (fx[127:80] != 48'd0) begin
            r.pcm = sgn ? 16'sh8000 : 16'sh7fff;
            r.clip = 1'b1;
            return r;
        end
        msb = 0;
        for (int i = 0; i < 40; i++)
            if (prod[i]) msb = i;
        kept = prod;
        if (msb > 23) begin
            drop = msb - 23;
            halfway = 40'd1 << (drop - 1);
            rem = prod & ((40'd1 << drop) - 40'd1);
            kept = prod >> drop;
            if (rem > halfway || (rem == halfway && kept[0]))
                kept = kept + 40'd1;
            kept = kept << drop;
        end
        fx = to_fixed(kept, sh);
        ip = fx[127:64];
        fr = fx[63:0];
        case (mode)
            MODE_AWAY: begin
                mag = ip + 64'(fr[63]);
            end
            MODE_TOWARD_ZERO: begin
                mag = ip;
            end
            default: begin
                mag = ip + 64'((fr > 64'h8000_0000_0000_0000) ||
                               (fr == 64'h8000_0000_0000_0000 && ip[0]));
            end
        endcase
        if (!sgn) begin
            if (mag > 64'd32767) begin
                r.pcm = 16'sh7fff;
                r.clip = 1'b1;
            end else begin
                r.pcm = mag[15:0];
            end
        end else begin
            if (mag > 64'd32768) begin
                r.pcm = 16'sh8000;
                r.clip = 1'b1;
            end else begin
                r.pcm = 16'(17'd0 - mag[16:0]);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] random_sample();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                // raw bits: covers every exponent and every bit
            end
            1: begin
                case ($urandom_range(0, 5))
                    0: b = {b[31], 8'hff, 23'd0};
                    1: b = {b[31], 8'hff, b[22:0] | 23'd1};
                    2: b = {b[31], 31'd0};
                    3: b = {b[31], 8'd0, b[22:0]};
                    4: b = {b[31], 8'd127, 23'd0};
                    default: b = {b[31], 8'd127, 16'd0, b[6:0]};
                endcase
            end
            2, 3: begin
                // few significant bits: many products land exactly on a half
                b = {b[31], 8'($urandom_range(112, 127)), b[22:14], 14'd0};
            end
            4: begin
                // just around full scale
                if (b[0]) b = {b[31], 8'd127, 16'd0, b[7:1]};
                else b = {b[31], 8'd126, 16'hffff, b[7:1]};
            end
            default: begin
                b = {b[31], 8'($urandom_range(100, 127)), b[22:0]};
            end
        endcase
        return b;
    endfunction

    task automatic write_mode(input logic [1:0] mode);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
        active_mode = mode;
        @(posedge aclk);
    endtask

    // Offer one sample after a random gap; hold until the transfer happens.
    task automatic send_sample(input logic [31:0] bits, input bit fixed,
                               input pcm_result_t fixed_res);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_bits <= bits;
        do @(posedge aclk); while (!s_ready);
        if (fixed) pending_pcm_q.push_back(fixed_res);
        else pending_pcm_q.push_back(predict_pcm(bits, active_mode));
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_pcm_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stalls, one long hold-off so the pipeline backs up.
    initial begin : pcm_sink
        int stall;
        pcm_result_t want;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (pcm_transfers == 150) stall = 300;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            pcm_transfers++;
            if (pending_pcm_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result pcm=%0d clip=%0b",
                                          m_pcm_value, m_clipped));
            end else begin
                want = pending_pcm_q.pop_front();
                if (m_pcm_value !== want.pcm)
                    report_mismatch($sformatf("pcm_value got %0d want %0d",
                                              m_pcm_value, want.pcm));
                if (m_clipped !== want.clip)
                    report_mismatch($sformatf("clipped got %0b want %0b (pcm %0d)",
                                              m_clipped, want.clip, want.pcm));
            end
        end
    end

    initial begin : sample_source
        sample_row_t directed[$];
        logic [1:0]  phase_modes[6];
        pcm_result_t fixed_res;
        // mode after reset is half away from zero
        directed = '{
            '{32'h0000_0000, 1, 16'sd0,      1'b0},
            '{32'h8000_0000, 1, 16'sd0,      1'b0},
            '{32'h3f80_0000, 1, 16'sd32767,  1'b0},
            '{32'hbf80_0000, 1, -16'sd32767, 1'b0},
            '{32'h3f00_0000, 1, 16'sd16384,  1'b0},
            '{32'hbf00_0000, 1, -16'sd16384, 1'b0},
            '{32'h7f80_0000, 1, 16'sh7fff,   1'b1},
            '{32'hff80_0000, 1, 16'sh8000,   1'b1},
            '{32'h7fc0_0000, 1, 16'sd0,      1'b1},
            '{32'hffff_ffff, 1, 16'sd0,      1'b1},
            '{32'h7f80_0001, 1, 16'sd0,      1'b1},
            '{32'h7f7f_ffff, 1, 16'sh7fff,   1'b1},
            '{32'hff7f_ffff, 1, 16'sh8000,   1'b1},
            '{32'h4000_0000, 1, 16'sh7fff,   1'b1},
            '{32'hc000_0000, 1, 16'sh8000,   1'b1},
            '{32'h0000_0001, 1, 16'sd0,      1'b0},
            '{32'h807f_ffff, 1, 16'sd0,      1'b0},
            '{32'h3f80_0001, 0, 16'sd0,      1'b0},
            '{32'hbf80_0001, 0, 16'sd0,      1'b0},
            '{32'hbf80_0100, 0, 16'sd0,      1'b0},
            '{32'h3e80_0000, 0, 16'sd0,      1'b0},
            '{32'h3f7f_ffff, 0, 16'sd0,      1'b0},
            '{32'h3880_0080, 0, 16'sd0,      1'b0},
            '{32'h477f_ff00, 0, 16'sd0,      1'b0}
        };
        phase_modes = '{MODE_TOWARD_ZERO, MODE_EVEN, MODE_SPARE, MODE_AWAY, MODE_EVEN,
                        MODE_TOWARD_ZERO};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            fixed_res.pcm = directed[i].pcm;
            fixed_res.clip = directed[i].clip;
            send_sample(directed[i].bits, directed[i].fixed, fixed_res);
        end

        // random phases, mode rewritten with the pipeline drained
        for (int p = 0; p < 6; p++) begin
            drain_pipeline();
            write_mode(phase_modes[p]);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
                send_sample(random_sample(), 0, fixed_res);
        end

        drain_pipeline();
        if (error_count == 0) begin
            $display("float_to_s16_rounding_converter_core_tb passed");
        end else begin
            $display("float_to_s16_rounding_converter_core_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
